// File: src/tcp_send_sequence_engine_macros.svh
// Assertion macros shared by the send sequence engine RTL.
`ifndef TCP_SEND_SEQUENCE_ENGINE_MACROS_SVH
`define TCP_SEND_SEQUENCE_ENGINE_MACROS_SVH

// same-cycle implication
`define TSSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define TSSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: src/tsse_pkg.sv
// Package: types, codes and constants of the TCP send sequence engine.
package tsse_pkg;

  localparam int unsigned BUF_W      = 13;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [BUF_W-1:0] SEND_BUF_BYTES = 13'd4096;

  localparam logic [15:0] MSS_RESET         = 16'd536;
  localparam logic [15:0] RTO_INIT_RESET    = 16'd1000;
  localparam logic [15:0] RTO_CEIL_RESET    = 16'd60000;
  localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd5;

  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_SYN     = 3'd1,
    KIND_FIN     = 3'd2,
    KIND_SEND    = 3'd3,
    KIND_ACK     = 3'd4,
    KIND_TIMEOUT = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_RESTART = 2'd1,
    TMR_STOP    = 2'd2
  } timer_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_ACK_BEYOND = 2'd1,
    STAT_ABORTED    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_MSS         = 2'd0,
    REG_RTO_INIT    = 2'd1,
    REG_RTO_CEIL    = 2'd2,
    REG_RETRY_LIMIT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] mss;
    logic [15:0] rto_init;
    logic [15:0] rto_ceil;
    logic [7:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [BUF_W-1:0] write_len;
    logic [31:0]      ack_number;
    logic [31:0]      rcv_next;
    logic [15:0]      rcv_window;
    logic             peer_isn_known;
    logic             peer_fin;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic [31:0]      seq;
    logic [31:0]      ack;
    logic [2:0]       flags;
    logic [15:0]      window;
    logic [BUF_W-1:0] offset;
    logic [BUF_W-1:0] len;
    logic [31:0]      nxt_next;
  } seg_t;

  typedef struct packed {
    logic             seg_valid;
    logic [31:0]      seg_seq;
    logic [31:0]      seg_ack;
    logic [2:0]       seg_flags;
    logic [15:0]      seg_window;
    logic [BUF_W-1:0] data_offset;
    logic [BUF_W-1:0] data_len;
    timer_cmd_e       timer_cmd;
    logic [15:0]      timer_value;
    logic [BUF_W-1:0] write_accepted;
    status_e          status;
    logic             space_freed;
  } result_t;

endpackage

// File: src/tsse_cfg_regs.sv
// Configuration register file behind the APB-style port.
module tsse_cfg_regs import tsse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MSS:         cfg_d.mss         = pwdata[15:0];
        REG_RTO_INIT:    cfg_d.rto_init    = pwdata[15:0];
        REG_RTO_CEIL:    cfg_d.rto_ceil    = pwdata[15:0];
        REG_RETRY_LIMIT: cfg_d.retry_limit = pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MSS:         prdata = 32'(cfg_q.mss);
      REG_RTO_INIT:    prdata = 32'(cfg_q.rto_init);
      REG_RTO_CEIL:    prdata = 32'(cfg_q.rto_ceil);
      REG_RETRY_LIMIT: prdata = 32'(cfg_q.retry_limit);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mss         <= MSS_RESET;
      cfg_q.rto_init    <= RTO_INIT_RESET;
      cfg_q.rto_ceil    <= RTO_CEIL_RESET;
      cfg_q.retry_limit <= RETRY_LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: src/tsse_seg_builder.sv
// Segment descriptor builder for new data and retransmission.
module tsse_seg_builder import tsse_pkg::*; (
  input  logic             rexmit_i,
  input  logic [31:0]      una_i,
  input  logic [31:0]      nxt_i,
  input  logic [BUF_W-1:0] buf_i,
  input  logic             syn_i,
  input  logic             fin_i,
  input  logic [15:0]      mss_i,
  input  item_t            item_i,
  output seg_t             seg_o
);

  logic [31:0]      off_full;
  logic [31:0]      base;
  logic [BUF_W-1:0] off;
  logic [BUF_W-1:0] avail;
  logic [BUF_W-1:0] len;
  logic             early;
  logic             fin_flag;

  always_comb begin
    off_full = nxt_i - una_i;
    early    = !rexmit_i && (off_full > 32'(buf_i));
    off      = rexmit_i ? '0 : off_full[BUF_W-1:0];
    avail    = buf_i - off;
    len      = (16'(avail) > mss_i) ? mss_i[BUF_W-1:0] : avail;
    fin_flag = (buf_i == '0) && fin_i;
    base     = rexmit_i ? una_i : nxt_i;

    seg_o          = '0;
    seg_o.nxt_next = nxt_i;
    if (!early && ((len != '0) || syn_i || fin_i)) begin
      seg_o.valid    = 1'b1;
      seg_o.seq      = base;
      seg_o.ack      = item_i.rcv_next;
      seg_o.flags    = {fin_flag, item_i.peer_isn_known, syn_i};
      seg_o.window   = item_i.rcv_window;
      seg_o.offset   = off;
      seg_o.len      = len;
      seg_o.nxt_next = base + 32'(syn_i) + 32'(fin_flag) + 32'(len);
    end
  end

endmodule

// File: src/tsse_ctrl.sv
// Connection state, event decode and retransmission state machine.
`include "tcp_send_sequence_engine_macros.svh"

module tsse_ctrl import tsse_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  typedef enum logic [1:0] {
    XS_IDLE    = 2'd0,
    XS_SENDING = 2'd1,
    XS_REXMIT  = 2'd2
  } xmit_state_e;

  xmit_state_e      xs_q, xs_d;
  logic [31:0]      una_q, una_d;
  logic [31:0]      nxt_q, nxt_d;
  logic [BUF_W-1:0] buf_q, buf_d;
  logic             syn_q, syn_d;
  logic             fin_q, fin_d;
  logic [15:0]      rto_q, rto_d;
  logic [7:0]       retry_q, retry_d;

  kind_e            kind;
  logic             is_send;
  logic             syn_eff;
  logic             fin_eff;
  logic             drained;
  logic             seg_rexmit;
  seg_t             seg;

  logic [BUF_W-1:0] buf_room;
  logic [BUF_W-1:0] acc;
  logic [16:0]      rto_x2;
  logic [15:0]      rto_dbl;
  logic [31:0]      d_una;
  logic [31:0]      d_nxt;
  logic [31:0]      una1;
  logic [31:0]      acked;
  logic [31:0]      unacked;
  logic [31:0]      cur;
  logic [BUF_W-1:0] removed;

  assign kind    = kind_e'(item_i.kind);
  assign is_send = (kind == KIND_SYN) || (kind == KIND_FIN) || (kind == KIND_SEND);
  assign syn_eff = syn_q || (kind == KIND_SYN);
  assign fin_eff = fin_q || (kind == KIND_FIN);
  assign drained = (una_q == nxt_q) || fin_eff;
  // sends carry new data except in the plain retransmit branch; timeouts resend
  assign seg_rexmit = is_send ? ((xs_q == XS_REXMIT) && !drained) : 1'b1;

  tsse_seg_builder u_seg (
    .rexmit_i (seg_rexmit),
    .una_i    (una_q),
    .nxt_i    (nxt_q),
    .buf_i    (buf_q),
    .syn_i    (syn_eff),
    .fin_i    (fin_eff),
    .mss_i    (cfg_i.mss),
    .item_i   (item_i),
    .seg_o    (seg)
  );

  always_comb begin
    buf_room = SEND_BUF_BYTES - buf_q;
    acc      = (item_i.write_len > buf_room) ? buf_room : item_i.write_len;
    rto_x2   = {rto_q, 1'b0};
    rto_dbl  = (rto_x2 >= 17'(cfg_i.rto_ceil)) ? cfg_i.rto_ceil : rto_x2[15:0];
    d_una    = item_i.ack_number - una_q;
    d_nxt    = item_i.ack_number - nxt_q;
    una1     = una_q + 32'(syn_q);
    acked    = item_i.ack_number - una1;
    unacked  = nxt_q - una1;
    cur      = (acked > unacked) ? unacked : acked;
    removed  = (cur > 32'(buf_q)) ? buf_q : cur[BUF_W-1:0];
  end

  always_comb begin
    xs_d    = xs_q;
    una_d   = una_q;
    nxt_d   = nxt_q;
    buf_d   = buf_q;
    syn_d   = syn_q;
    fin_d   = fin_q;
    rto_d   = rto_q;
    retry_d = retry_q;
    res_o   = '0;

    unique case (kind) inside
      KIND_WRITE: begin
        buf_d                = buf_q + acc;
        res_o.write_accepted = acc;
      end
      KIND_SYN, KIND_FIN, KIND_SEND: begin
        syn_d = syn_eff;
        fin_d = fin_eff;
        if ((xs_q == XS_IDLE) ||
            (((xs_q == XS_SENDING) || (xs_q == XS_REXMIT)) && drained &&
             ((buf_q != '0) || item_i.peer_fin))) begin
          nxt_d             = seg.nxt_next;
          xs_d              = XS_SENDING;
          res_o.timer_cmd   = TMR_RESTART;
          res_o.timer_value = rto_q;
          res_o.seg_valid   = seg.valid;
        end else if (((xs_q == XS_SENDING) || (xs_q == XS_REXMIT)) && drained) begin
          xs_d            = XS_IDLE;
          rto_d           = cfg_i.rto_init;
          res_o.timer_cmd = TMR_STOP;
        end else if (xs_q == XS_REXMIT) begin
          nxt_d             = seg.nxt_next;
          res_o.timer_cmd   = TMR_RESTART;
          res_o.timer_value = rto_q;
          res_o.seg_valid   = seg.valid;
        end
      end
      KIND_ACK: begin
        if ((d_una == '0) || d_una[31]) begin
          // old or duplicate ack
        end else if (!d_nxt[31] && (d_nxt != '0)) begin
          res_o.status = STAT_ACK_BEYOND;
        end else begin
          syn_d = 1'b0;
          una_d = una1;
          if (cur != '0) begin
            res_o.space_freed = 1'b1;
            una_d             = una1 + cur;
            buf_d             = buf_q - removed;
            if (fin_q && (cur != 32'(removed))) begin
              fin_d = 1'b0;
            end
          end
        end
      end
      KIND_TIMEOUT: begin
        if ((xs_q == XS_REXMIT) && (retry_q >= cfg_i.retry_limit)) begin
          xs_d            = XS_IDLE;
          rto_d           = cfg_i.rto_init;
          retry_d         = '0;
          res_o.timer_cmd = TMR_STOP;
          res_o.status    = STAT_ABORTED;
        end else if ((xs_q == XS_SENDING) || (xs_q == XS_REXMIT)) begin
          nxt_d             = seg.nxt_next;
          retry_d           = (xs_q == XS_SENDING) ? 8'd1 : retry_q + 8'd1;
          rto_d             = rto_dbl;
          xs_d              = XS_REXMIT;
          res_o.timer_cmd   = TMR_RESTART;
          res_o.timer_value = rto_dbl;
          res_o.seg_valid   = seg.valid;
        end
      end
      default: begin
      end
    endcase

    if (res_o.seg_valid) begin
      res_o.seg_seq     = seg.seq;
      res_o.seg_ack     = seg.ack;
      res_o.seg_flags   = seg.flags;
      res_o.seg_window  = seg.window;
      res_o.data_offset = seg.offset;
      res_o.data_len    = seg.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_q    <= XS_IDLE;
      una_q   <= '0;
      nxt_q   <= '0;
      buf_q   <= '0;
      syn_q   <= 1'b0;
      fin_q   <= 1'b0;
      rto_q   <= RTO_INIT_RESET;
      retry_q <= '0;
    end else if (fire_i) begin
      xs_q    <= xs_d;
      una_q   <= una_d;
      nxt_q   <= nxt_d;
      buf_q   <= buf_d;
      syn_q   <= syn_d;
      fin_q   <= fin_d;
      rto_q   <= rto_d;
      retry_q <= retry_d;
    end
  end

  `TSSE_ASSERT_IMP(a_buf_bound, clk_i, rst_ni, 1'b1, buf_q <= SEND_BUF_BYTES)
  `TSSE_ASSERT_NXT(a_abort_idle, clk_i, rst_ni,
                   fire_i && (res_o.status == STAT_ABORTED),
                   (xs_q == XS_IDLE) && (retry_q == '0))
  `TSSE_ASSERT_NXT(a_beyond_hold, clk_i, rst_ni,
                   fire_i && (res_o.status == STAT_ACK_BEYOND),
                   $stable(una_q) && $stable(nxt_q) && $stable(buf_q))

endmodule

// File: src/tcp_send_sequence_engine.sv
// Top level of the TCP send sequence engine.
// Input channel: in_valid_i / in_stall_o carry one event item (kind, write
// length, ack number, receive next/window, peer ISN known flag, peer_fin). An
// item is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry one result item per input
// item: segment descriptor, timer command, accepted write length, status
// and writer wake flag, in input order.
// An item taken waits in the input register and is processed from there into
// the result register once that register is free.
// Throughput: one item per cycle while the result register is free; the
// connection state updates in the same cycle that loads the result register,
// so the next item sees it directly. While out_stall_i holds a result, one
// more item waits in the input register and then in_stall_o rises.
// Reset (rst_ni low, asynchronous): both channels empty, sequences and buffer
// count zero, state idle, registers at their reset values. Configuration goes
// through the APB-style port while the block is idle: a user duty, not enforced.
`include "tcp_send_sequence_engine_macros.svh"

module tcp_send_sequence_engine import tsse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            kind_i,
  input  logic [BUF_W-1:0]      write_len_i,
  input  logic [31:0]           ack_number_i,
  input  logic [31:0]           rcv_next_i,
  input  logic [15:0]           rcv_window_i,
  input  logic                  peer_isn_known_i,
  input  logic                  peer_fin_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  seg_valid_o,
  output logic [31:0]           seg_seq_o,
  output logic [31:0]           seg_ack_o,
  output logic [2:0]            seg_flags_o,
  output logic [15:0]           seg_window_o,
  output logic [BUF_W-1:0]      data_offset_o,
  output logic [BUF_W-1:0]      data_len_o,
  output logic [1:0]            timer_cmd_o,
  output logic [15:0]           timer_value_o,
  output logic [BUF_W-1:0]      write_accepted_o,
  output logic [1:0]            status_o,
  output logic                  space_freed_o
);

  cfg_t    cfg;
  item_t   in_item_q, in_item_d;
  logic    in_valid_q, in_valid_d;
  result_t res;
  result_t out_res_q, out_res_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  logic    fire;
  logic    accept;

  tsse_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsse_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_item_d = in_item_q;
    if (accept) begin
      in_item_d.kind           = kind_i;
      in_item_d.write_len      = write_len_i;
      in_item_d.ack_number     = ack_number_i;
      in_item_d.rcv_next       = rcv_next_i;
      in_item_d.rcv_window     = rcv_window_i;
      in_item_d.peer_isn_known = peer_isn_known_i;
      in_item_d.peer_fin       = peer_fin_i;
    end
    in_valid_d  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);
    out_res_d   = fire ? res : out_res_q;
    out_valid_d = fire ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q <= in_item_d;
    out_res_q <= out_res_d;
  end

  assign out_valid_o      = out_valid_q;
  assign seg_valid_o      = out_res_q.seg_valid;
  assign seg_seq_o        = out_res_q.seg_seq;
  assign seg_ack_o        = out_res_q.seg_ack;
  assign seg_flags_o      = out_res_q.seg_flags;
  assign seg_window_o     = out_res_q.seg_window;
  assign data_offset_o    = out_res_q.data_offset;
  assign data_len_o       = out_res_q.data_len;
  assign timer_cmd_o      = out_res_q.timer_cmd;
  assign timer_value_o    = out_res_q.timer_value;
  assign write_accepted_o = out_res_q.write_accepted;
  assign status_o         = out_res_q.status;
  assign space_freed_o    = out_res_q.space_freed;

  `TSSE_ASSERT_IMP(a_empty_no_stall, clk_i, rst_ni, !out_valid_q, !in_stall_o)
  `TSSE_ASSERT_NXT(a_fire_loads, clk_i, rst_ni, fire, out_valid_q)
  `TSSE_ASSERT_NXT(a_accept_loads, clk_i, rst_ni, in_valid_i && !in_stall_o, in_valid_q)

endmodule
